// ----- design/pmdc_pkg.sv -----
// Shared constants for the periodic minimum distance checker.
`default_nettype none
package pmdc_pkg;
  localparam int MAX_ATOMS = 256;
  localparam int IDX_W = $clog2(MAX_ATOMS);
  localparam int CNT_W = $clog2(MAX_ATOMS + 1);

  localparam logic [1:0] ACT_LATTICE = 2'd0;
  localparam logic [1:0] ACT_APPEND  = 2'd1;
  localparam logic [1:0] ACT_CHECK   = 2'd2;
  localparam logic [1:0] ACT_CLEAR   = 2'd3;

  localparam logic [2:0] ST_LOAD_OK   = 3'd0;
  localparam logic [2:0] ST_LOAD_FULL = 3'd1;
  localparam logic [2:0] ST_CLEAN     = 3'd2;
  localparam logic [2:0] ST_WARN      = 3'd3;
  localparam logic [2:0] ST_CLOSE     = 3'd4;

  localparam logic [15:0] FACTOR_RESET = 16'd8192;
  localparam logic [15:0] WARN_COEF    = 16'd9830;  // 0.6 in Q2.14
  localparam logic [19:0] COUNT_MAX    = 20'hFFFFF;
endpackage
`default_nettype wire

// ----- design/periodic_min_distance_check_top.sv -----
// Periodic minimum distance checker: atom store, pair walk sequencer and shared multiplier.
// Loads (lattice, append, clear) are answered with a registered result.
// A check of N atoms walks N*(N+1)/2 pairs of 27 images each; the zero image of a self
// pair is skipped. An image is one setup step, three passes of nine steps, then a compare.
// Throughput: one request at a time; a new request is taken while a result waits
// if the result is taken in that same cycle. Synchronous active-high reset clears
// the atom count, sequencer and output valid, presets factor; atom and lattice stores stay.
`default_nettype none
module periodic_min_distance_check_top (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // s_tuser: action[1:0]
  input  wire logic [1:0]   s_tuser,
  // s_tdata: lattice_index[3:0], lattice_value[35:4], frac_x[59:36],
  //          frac_y[83:60], frac_z[107:84], radius[123:108], zero pad
  input  wire logic [127:0] s_tdata,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // m_tuser: status[2:0]
  output logic [2:0]        m_tuser,
  // m_tdata: error_pairs[19:0], warning_pairs[39:20], first_atom[47:40],
  //          second_atom[55:48], image_a[57:56], image_b[59:58], image_c[61:60], zero pad
  output logic [63:0]       m_tdata,
  input  wire logic         cfg_we,
  input  wire logic [15:0]  cfg_wdata
);
  import pmdc_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_WI   = 4'd1;
  localparam logic [3:0] S_GI   = 4'd2;
  localparam logic [3:0] S_WJ   = 4'd3;
  localparam logic [3:0] S_GJ   = 4'd4;
  localparam logic [3:0] S_THR  = 4'd5;
  localparam logic [3:0] S_IMG  = 4'd6;
  localparam logic [3:0] S_CMP  = 4'd7;
  localparam logic [3:0] S_FIN  = 4'd8;

  // atom store: {radius, z, y, x}
  logic [87:0] mem [MAX_ATOMS];
  logic [87:0] rdata;
  logic [IDX_W-1:0] rd_addr;

  logic [31:0] lat [9];
  logic [15:0] factor;
  logic [CNT_W-1:0] atom_count;

  logic [3:0] state;
  logic [3:0] ustep;
  logic [1:0] k;
  logic [CNT_W-1:0] i, j;
  logic signed [1:0] ia, ib, ic;

  logic [23:0] ai_x, ai_y, ai_z, aj_x, aj_y, aj_z;
  logic [15:0] ai_r, aj_r;
  logic [25:0] dx, dy, dz;
  logic [59:0] comp, mag;
  logic [32:0] se, sw;
  logic [65:0] te, tw;
  logic [119:0] d2;

  logic [19:0] err_cnt, warn_cnt;
  logic have_err, have_warn;
  logic [7:0] e_i, e_j, w_i, w_j;
  logic [1:0] e_a, e_b, e_c, w_a, w_b, w_c;

  logic signed [33:0] mul_a, mul_b;
  logic signed [67:0] prod;

  logic [16:0] rsum;
  logic skip, img_last, adv, is_err, is_warn;
  logic [119:0] te_sh, tw_sh;
  logic [3:0] li;

  assign s_tready = (state == S_IDLE) && (!m_tvalid || m_tready);
  assign li = s_tdata[3:0];
  assign rsum = {1'b0, ai_r} + {1'b0, aj_r};
  assign skip = (i == j) && (ia == 2'sd0) && (ib == 2'sd0) && (ic == 2'sd0);
  assign img_last = (ia == 2'sd1) && (ib == 2'sd1) && (ic == 2'sd1);
  assign te_sh = {34'd0, te, 20'd0};
  assign tw_sh = {34'd0, tw, 20'd0};
  assign is_err = d2 < te_sh;
  assign is_warn = !is_err && (d2 < tw_sh);
  assign adv = (state == S_CMP) || ((state == S_IMG) && (ustep == 4'd0) && skip);
  assign mag = comp[59] ? (~comp + 60'd1) : comp;

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_THR: begin
        case (ustep)
          4'd0: begin mul_a = {17'd0, rsum}; mul_b = {18'd0, factor}; end
          4'd1: begin mul_a = {17'd0, rsum}; mul_b = {18'd0, WARN_COEF}; end
          4'd2: begin mul_a = {1'b0, se}; mul_b = {1'b0, se}; end
          4'd3: begin mul_a = {1'b0, sw}; mul_b = {1'b0, sw}; end
          default: ;
        endcase
      end
      S_IMG: begin
        case (ustep)
          4'd1: begin
            mul_a = {{8{dx[25]}}, dx};
            mul_b = {{2{lat[4'(k)][31]}}, lat[4'(k)]};
          end
          4'd2: begin
            mul_a = {{8{dy[25]}}, dy};
            mul_b = {{2{lat[4'(k) + 4'd3][31]}}, lat[4'(k) + 4'd3]};
          end
          4'd3: begin
            mul_a = {{8{dz[25]}}, dz};
            mul_b = {{2{lat[4'(k) + 4'd6][31]}}, lat[4'(k) + 4'd6]};
          end
          4'd6: begin mul_a = {4'd0, comp[29:0]}; mul_b = {4'd0, comp[29:0]}; end
          4'd7: begin mul_a = {4'd0, comp[29:0]}; mul_b = {4'd0, comp[59:30]}; end
          4'd8: begin mul_a = {4'd0, comp[59:30]}; mul_b = {4'd0, comp[59:30]}; end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      m_tvalid <= 1'b0;
      atom_count <= '0;
      factor <= FACTOR_RESET;
      ustep <= '0;
    end else begin
      if (cfg_we) factor <= cfg_wdata;

      case (state)
        S_IDLE: begin
          if (s_tvalid && s_tready) begin
            case (s_tuser)
              ACT_LATTICE: begin
                if (li < 4'd9) lat[li] <= s_tdata[35:4];
                m_tvalid <= 1'b1;
                m_tuser <= ST_LOAD_OK;
                m_tdata <= '0;
              end
              ACT_APPEND: begin
                m_tvalid <= 1'b1;
                m_tdata <= '0;
                if (atom_count >= CNT_W'(MAX_ATOMS)) begin
                  m_tuser <= ST_LOAD_FULL;
                end else begin
                  m_tuser <= ST_LOAD_OK;
                  mem[atom_count[IDX_W-1:0]] <= s_tdata[123:36];
                  atom_count <= atom_count + 1'b1;
                end
              end
              ACT_CLEAR: begin
                atom_count <= '0;
                m_tvalid <= 1'b1;
                m_tuser <= ST_LOAD_OK;
                m_tdata <= '0;
              end
              ACT_CHECK: begin
                if (atom_count == '0) begin
                  m_tvalid <= 1'b1;
                  m_tuser <= ST_CLEAN;
                  m_tdata <= '0;
                end else begin
                  m_tvalid <= 1'b0;
                  i <= '0;
                  j <= '0;
                  rd_addr <= '0;
                  err_cnt <= '0;
                  warn_cnt <= '0;
                  have_err <= 1'b0;
                  have_warn <= 1'b0;
                  state <= S_WI;
                end
              end
              default: ;
            endcase
          end else if (m_tvalid && m_tready) begin
            m_tvalid <= 1'b0;
          end
        end
        S_WI: state <= S_GI;
        S_GI: begin
          {ai_r, ai_z, ai_y, ai_x} <= rdata;
          rd_addr <= j[IDX_W-1:0];
          state <= S_WJ;
        end
        S_WJ: state <= S_GJ;
        S_GJ: begin
          {aj_r, aj_z, aj_y, aj_x} <= rdata;
          ia <= -2'sd1;
          ib <= -2'sd1;
          ic <= -2'sd1;
          ustep <= '0;
          state <= S_THR;
        end
        S_THR: begin
          ustep <= (ustep == 4'd4) ? 4'd0 : ustep + 1'b1;
          case (ustep)
            4'd1: se <= prod[32:0];
            4'd2: sw <= prod[32:0];
            4'd3: te <= prod[65:0];
            4'd4: begin
              tw <= prod[65:0];
              state <= S_IMG;
            end
            default: ;
          endcase
        end
        S_IMG: begin
          // a skipped self image is handled by the step logic below
          if (!adv) begin
            ustep <= (ustep == 4'd9) ? 4'd1 : ustep + 1'b1;
            case (ustep)
              4'd0: begin
                dx <= {{2{aj_x[23]}}, aj_x} - {{2{ai_x[23]}}, ai_x} + {{4{ia[1]}}, ia, 20'd0};
                dy <= {{2{aj_y[23]}}, aj_y} - {{2{ai_y[23]}}, ai_y} + {{4{ib[1]}}, ib, 20'd0};
                dz <= {{2{aj_z[23]}}, aj_z} - {{2{ai_z[23]}}, ai_z} + {{4{ic[1]}}, ic, 20'd0};
                d2 <= '0;
                k <= '0;
              end
              4'd2: comp <= prod[59:0];
              4'd3: comp <= comp + prod[59:0];
              4'd4: comp <= comp + prod[59:0];
              4'd5: comp <= mag;
              4'd7: d2 <= d2 + {60'd0, prod[59:0]};
              4'd8: d2 <= d2 + ({60'd0, prod[59:0]} << 31);
              4'd9: begin
                d2 <= d2 + ({60'd0, prod[59:0]} << 60);
                if (k == 2'd2) state <= S_CMP;
                else k <= k + 1'b1;
              end
              default: ;
            endcase
          end
        end
        S_CMP: begin
          if (is_err) begin
            if (err_cnt != COUNT_MAX) err_cnt <= err_cnt + 1'b1;
            if (!have_err) begin
              have_err <= 1'b1;
              e_i <= 8'(i); e_j <= 8'(j);
              e_a <= ia; e_b <= ib; e_c <= ic;
            end
          end else if (is_warn) begin
            if (warn_cnt != COUNT_MAX) warn_cnt <= warn_cnt + 1'b1;
            if (!have_warn) begin
              have_warn <= 1'b1;
              w_i <= 8'(i); w_j <= 8'(j);
              w_a <= ia; w_b <= ib; w_c <= ic;
            end
          end
        end
        S_FIN: begin
          m_tvalid <= 1'b1;
          if (have_err) begin
            m_tuser <= ST_CLOSE;
            m_tdata <= {2'b0, e_c, e_b, e_a, e_j, e_i, warn_cnt, err_cnt};
          end else if (have_warn) begin
            m_tuser <= ST_WARN;
            m_tdata <= {2'b0, w_c, w_b, w_a, w_j, w_i, warn_cnt, err_cnt};
          end else begin
            m_tuser <= ST_CLEAN;
            m_tdata <= {24'd0, warn_cnt, err_cnt};
          end
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase

      // step to next image, next pair or finish
      if (adv) begin
        ustep <= '0;
        if (!img_last) begin
          state <= S_IMG;
          if (ic != 2'sd1) ic <= ic + 2'sd1;
          else begin
            ic <= -2'sd1;
            if (ib != 2'sd1) ib <= ib + 2'sd1;
            else begin
              ib <= -2'sd1;
              ia <= ia + 2'sd1;
            end
          end
        end else if (j + 1'b1 < atom_count) begin
          j <= j + 1'b1;
          rd_addr <= IDX_W'(j + 1'b1);
          state <= S_WJ;
        end else if (i + 1'b1 < atom_count) begin
          i <= i + 1'b1;
          j <= i + 1'b1;
          rd_addr <= IDX_W'(i + 1'b1);
          state <= S_WI;
        end else begin
          state <= S_FIN;
        end
      end
    end
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> (state == S_IDLE)) else $error("ready outside idle");
  a_pair_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_CMP) |-> ((j >= i) && (j < atom_count))) else $error("pair index out of range");
  a_fin_result: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN) |=> m_tvalid) else $error("check finished without result");
endmodule
`default_nettype wire
